### hdl/isk_pkg.sv
// isk_pkg: sizes, opcodes, status codes and controller/datapath command types
// for the integer stack engine; no dependencies, used by every other file
package isk_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int OP_W       = 3;
	localparam int VAL_W      = 32;
	localparam int ST_W       = 3;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 3'd0,
		OP_DUMP = 3'd1,
		OP_PEEK = 3'd2,
		OP_POP  = 3'd3,
		OP_SWAP = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK         = 3'd0,
		ST_FULL       = 3'd1,
		ST_PEEK_EMPTY = 3'd2,
		ST_POP_EMPTY  = 3'd3,
		ST_SWAP_SHORT = 3'd4,
		ST_DUMP_EMPTY = 3'd5,
		ST_VALUE      = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SWAP_RD,
		S_SWAP_WR,
		S_DUMP
	} state_t;

	typedef enum logic [1:0] {
		RA_TOP,
		RA_SECOND,
		RA_NEXT
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_PUSH,
		WR_SWAP_HI,
		WR_SWAP_LO
	} wr_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	typedef struct packed {
		logic    ld;
		logic    rd_en;
		rd_sel_t ra_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		cnt_op_t cnt_op;
		logic    tmp_ld;
		logic    ptr_ld;
		logic    ptr_dec;
		logic    emit;
		logic    use_mem;
		status_t code;
		logic    last;
	} isk_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic             empty;
		logic             full;
		logic             few;
		logic             ptr_zero;
		logic             out_free;
		logic [CNT_W-1:0] count;
	} isk_stat_t;

endpackage

### hdl/isk_in_if.sv
// isk_in_if: request channel of the stack engine, valid/ready with opcode and value
// depends on isk_pkg for field widths
interface isk_in_if;
	logic                                valid;
	logic                                ready;
	logic [isk_pkg::OP_W-1:0]            operation;
	logic signed [isk_pkg::VAL_W-1:0]    value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

### hdl/isk_out_if.sv
// isk_out_if: result channel of the stack engine, valid/ready with data, status, last
// depends on isk_pkg for field widths
interface isk_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [isk_pkg::VAL_W-1:0]    data;
	logic [isk_pkg::ST_W-1:0]            status;
	logic                                last;

	modport source (output valid, output data, output status, output last, input ready);
	modport sink (input valid, input data, input status, input last, output ready);
endinterface

### hdl/integer_stack_engine.sv
// integer_stack_engine: top level of a bounded lifo of signed integers
// depends on isk_pkg, isk_in_if, isk_out_if, isk_ctrl and isk_dp
//
// usage
// - req carries one opcode (push, dump, peek, pop, swap) and a push value per
//   transaction; rsp returns result transactions with data, status and last,
//   last marking the final result of each request
// - push, pop and peek write their result into the result register once it is
//   free; swap reads the two top entries and writes them back exchanged (two
//   reads and two writes on the entry memory); dump loads the dump pointer, then
//   issues one entry per cycle while rsp is ready; undefined opcodes are dropped with no result
// - req is ready only between requests, so a new request is taken once the
//   previous one has issued its last result into the result register; that
//   result may still wait on rsp while the next request is taken
// - the result register holds a stalled result; the sequencer waits with
//   the next result until rsp takes it
// - reset empties the stack and marks the result register empty; entry memory is
//   not cleared, entries at or above the count are never used in a result
// - failing pushes (full) and swaps (short) empty the stack; other failing requests leave it
module integer_stack_engine (
	input  logic      clk,
	input  logic      arst_n,
	isk_in_if.sink    req,
	isk_out_if.source rsp
);
	import isk_pkg::*;

	isk_cmd_t  cmd;
	isk_stat_t stat;
	logic      accept;

	assign accept = req.valid && req.ready;

	isk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.stat   (stat),
		.ready  (req.ready),
		.cmd    (cmd)
	);

	isk_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operation (req.operation),
		.value     (req.value),
		.stat      (stat),
		.rsp       (rsp)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result register overwritten while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request taken while previous one in progress");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && cmd.wr_sel == WR_PUSH) |=> stat.count == $past(stat.count) + CNT_W'(1))
		else $error("push did not grow the stack");

endmodule

### hdl/isk_ctrl.sv
// isk_ctrl: sequencer of the stack engine, one state machine issuing datapath commands
// depends on isk_pkg
module isk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  isk_pkg::isk_stat_t stat,
	output logic               ready,
	output isk_pkg::isk_cmd_t  cmd
);
	import isk_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		ready     = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				ready = 1'b1;
				if (accept) begin
					cmd.ld     = 1'b1;
					cmd.rd_en  = 1'b1;
					cmd.ra_sel = RA_TOP;
					state_nxt  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.op)
					OP_PUSH: begin
						if (stat.out_free) begin
							cmd.emit  = 1'b1;
							cmd.last  = 1'b1;
							state_nxt = S_IDLE;
							if (stat.full) begin
								cmd.code   = ST_FULL;
								cmd.cnt_op = CNT_CLR;
							end else begin
								cmd.code   = ST_OK;
								cmd.wr_en  = 1'b1;
								cmd.wr_sel = WR_PUSH;
								cmd.cnt_op = CNT_INC;
							end
						end
					end
					OP_POP: begin
						if (stat.out_free) begin
							cmd.emit  = 1'b1;
							cmd.last  = 1'b1;
							state_nxt = S_IDLE;
							if (stat.empty) begin
								cmd.code = ST_POP_EMPTY;
							end else begin
								cmd.code   = ST_OK;
								cmd.cnt_op = CNT_DEC;
							end
						end
					end
					OP_PEEK: begin
						if (stat.out_free) begin
							cmd.emit  = 1'b1;
							cmd.last  = 1'b1;
							state_nxt = S_IDLE;
							if (stat.empty) begin
								cmd.code = ST_PEEK_EMPTY;
							end else begin
								cmd.code    = ST_VALUE;
								cmd.use_mem = 1'b1;
							end
						end
					end
					OP_SWAP: begin
						if (stat.few) begin
							if (stat.out_free) begin
								cmd.emit   = 1'b1;
								cmd.last   = 1'b1;
								cmd.code   = ST_SWAP_SHORT;
								cmd.cnt_op = CNT_CLR;
								state_nxt  = S_IDLE;
							end
						end else begin
							cmd.tmp_ld = 1'b1;
							cmd.rd_en  = 1'b1;
							cmd.ra_sel = RA_SECOND;
							state_nxt  = S_SWAP_RD;
						end
					end
					OP_DUMP: begin
						if (stat.empty) begin
							if (stat.out_free) begin
								cmd.emit  = 1'b1;
								cmd.last  = 1'b1;
								cmd.code  = ST_DUMP_EMPTY;
								state_nxt = S_IDLE;
							end
						end else begin
							cmd.ptr_ld = 1'b1;
							state_nxt  = S_DUMP;
						end
					end
					default: begin
						// undefined opcode: dropped without a result
						state_nxt = S_IDLE;
					end
				endcase
			end
			S_SWAP_RD: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SWAP_HI;
				state_nxt  = S_SWAP_WR;
			end
			S_SWAP_WR: begin
				if (stat.out_free) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_SWAP_LO;
					cmd.emit   = 1'b1;
					cmd.last   = 1'b1;
					cmd.code   = ST_OK;
					state_nxt  = S_IDLE;
				end
			end
			S_DUMP: begin
				if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.use_mem = 1'b1;
					cmd.code    = ST_VALUE;
					cmd.last    = stat.ptr_zero;
					if (stat.ptr_zero) begin
						state_nxt = S_IDLE;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.ra_sel  = RA_NEXT;
						cmd.ptr_dec = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

### hdl/isk_dp.sv
// isk_dp: datapath of the stack engine: entry memory, entry count, dump pointer,
// swap holding register and result register; depends on isk_pkg and isk_out_if
module isk_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  isk_pkg::isk_cmd_t                   cmd,
	input  logic [isk_pkg::OP_W-1:0]            operation,
	input  logic signed [isk_pkg::VAL_W-1:0]    value,
	output isk_pkg::isk_stat_t                  stat,
	isk_out_if.source                           rsp
);
	import isk_pkg::*;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [DATA_WIDTH-1:0] tmp_q;
	logic [OP_W-1:0]       op_q;
	logic [VAL_W-1:0]      val_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      ptr_q;
	logic                  out_valid_q;
	logic [VAL_W-1:0]      out_data_q;
	logic [ST_W-1:0]       out_status_q;
	logic                  out_last_q;

	logic [CNT_W-1:0]      cnt_m1;
	logic [CNT_W-1:0]      cnt_m2;
	logic [IDX_W-1:0]      top_idx;
	logic [IDX_W-1:0]      second_idx;
	logic [IDX_W-1:0]      push_idx;
	logic [IDX_W-1:0]      rd_addr;
	logic [IDX_W-1:0]      wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;

	assign cnt_m1     = count_q - CNT_W'(1);
	assign cnt_m2     = count_q - CNT_W'(2);
	assign top_idx    = cnt_m1[IDX_W-1:0];
	assign second_idx = cnt_m2[IDX_W-1:0];
	assign push_idx   = count_q[IDX_W-1:0];

	always_comb begin
		unique case (cmd.ra_sel)
			RA_TOP:    rd_addr = top_idx;
			RA_SECOND: rd_addr = second_idx;
			RA_NEXT:   rd_addr = ptr_q - IDX_W'(1);
			default:   rd_addr = top_idx;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WR_PUSH: begin
				wr_addr = push_idx;
				wr_data = DATA_WIDTH'($unsigned(val_q));
			end
			WR_SWAP_HI: begin
				wr_addr = top_idx;
				wr_data = rd_data_q;
			end
			WR_SWAP_LO: begin
				wr_addr = second_idx;
				wr_data = tmp_q;
			end
			default: begin
				wr_addr = push_idx;
				wr_data = tmp_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			op_q  <= operation;
			val_q <= value;
		end
		if (cmd.tmp_ld) begin
			tmp_q <= rd_data_q;
		end
		if (cmd.ptr_ld) begin
			ptr_q <= top_idx;
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - IDX_W'(1);
		end
		if (cmd.emit) begin
			out_data_q   <= cmd.use_mem ? VAL_W'(rd_data_q) : '0;
			out_status_q <= cmd.code;
			out_last_q   <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.cnt_op)
				CNT_HOLD: count_q <= count_q;
				CNT_INC:  count_q <= count_q + CNT_W'(1);
				CNT_DEC:  count_q <= cnt_m1;
				CNT_CLR:  count_q <= '0;
				default:  count_q <= count_q;
			endcase
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.op       = op_q;
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CNT_W'(DEPTH));
	assign stat.few      = (count_q < CNT_W'(2));
	assign stat.ptr_zero = (ptr_q == '0);
	assign stat.out_free = !out_valid_q || rsp.ready;
	assign stat.count    = count_q;

	assign rsp.valid  = out_valid_q;
	assign rsp.data   = out_data_q;
	assign rsp.status = out_status_q;
	assign rsp.last   = out_last_q;

endmodule
